@@ hdl/clcd_pkg.sv @@
// Shared constants, codes and types of the character LCD command sequencer.
`default_nettype none

package clcd_pkg;

   // Text buffer
   localparam int BUFFER_DEPTH = 32;
   localparam int BUF_IDX_W    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   // Field widths
   localparam int OPCODE_W   = 3;
   localparam int CHAR_IDX_W = 5;
   localparam int BYTE_W     = 8;
   localparam int TEXT_LEN_W = 6;
   localparam int STATUS_W   = 2;
   localparam int DONE_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OPC_TICK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OPC_LOAD  = 3'd1;
   localparam logic [OPCODE_W-1:0] OPC_WRITE = 3'd2;
   localparam logic [OPCODE_W-1:0] OPC_CLEAR = 3'd3;
   localparam logic [OPCODE_W-1:0] OPC_MOVE  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INUSE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd2;

   // Completion codes
   localparam logic [DONE_W-1:0] DONE_NONE  = 2'd0;
   localparam logic [DONE_W-1:0] DONE_WRITE = 2'd1;
   localparam logic [DONE_W-1:0] DONE_CLEAR = 2'd2;
   localparam logic [DONE_W-1:0] DONE_MOVE  = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FUNCTION = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DISPLAY  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRY    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_ONE = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_TWO = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_POS  = 3'd5;

   // LCD command bytes
   localparam logic [BYTE_W-1:0] CMD_FUNCTION = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY  = 8'h08;
   localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_ENTRY    = 8'h04;

   typedef enum logic [3:0] {
      ACT_IDLE  = 4'b0001,
      ACT_CLEAR = 4'b0010,
      ACT_WRITE = 4'b0100,
      ACT_MOVE  = 4'b1000
   } active_type;

   typedef struct packed {
      logic [1:0]        function_bits;
      logic [2:0]        display_bits;
      logic [1:0]        entry_bits;
      logic [BYTE_W-1:0] line_one_cmd;
      logic [BYTE_W-1:0] line_two_cmd;
      logic [BYTE_W-1:0] max_position;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [CHAR_IDX_W-1:0] char_index;
      logic [BYTE_W-1:0]     char_value;
      logic [TEXT_LEN_W-1:0] text_length;
      logic [BYTE_W-1:0]     line_select;
      logic [BYTE_W-1:0]     position;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                reg_select;
      logic                enable;
      logic [BYTE_W-1:0]   data_bus;
      logic [DONE_W-1:0]   done_kind;
      logic                init_done;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/clcd_ifs.sv @@
// Handshake interfaces of the sequencer: request, response and register write channels.
`default_nettype none

interface clcd_req_if;
   logic                                valid;
   logic                                ready;
   logic [clcd_pkg::OPCODE_W-1:0]       opcode;
   logic [clcd_pkg::CHAR_IDX_W-1:0]     char_index;
   logic [clcd_pkg::BYTE_W-1:0]         char_value;
   logic [clcd_pkg::TEXT_LEN_W-1:0]     text_length;
   logic [clcd_pkg::BYTE_W-1:0]         line_select;
   logic [clcd_pkg::BYTE_W-1:0]         position;

   modport source (output valid, opcode, char_index, char_value, text_length,
                   line_select, position, input ready);
   modport sink (input valid, opcode, char_index, char_value, text_length,
                 line_select, position, output ready);
endinterface

interface clcd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [clcd_pkg::STATUS_W-1:0]     status;
   logic                              reg_select;
   logic                              enable;
   logic [clcd_pkg::BYTE_W-1:0]       data_bus;
   logic [clcd_pkg::DONE_W-1:0]       done_kind;
   logic                              init_done;

   modport source (output valid, status, reg_select, enable, data_bus, done_kind,
                   init_done, input ready);
   modport sink (input valid, status, reg_select, enable, data_bus, done_kind,
                 init_done, output ready);
endinterface

interface clcd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [clcd_pkg::CSR_ADDR_W-1:0]     index;
   logic [clcd_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/char_lcd_command_sequencer.sv @@
// Top level of the character LCD command sequencer: channel registers around the core.
//
//   channel  | port    | direction | transaction carries
//   ---------+---------+-----------+-------------------------------------------------
//   request  | req_if  | in        | opcode, char_index, char_value, text_length,
//            |         |           | line_select, position
//   response | rsp_if  | out       | status, reg_select, enable, data_bus, done_kind,
//            |         |           | init_done
//   config   | csr_if  | in        | register index, write data (always ready)
//
// One request transaction yields exactly one response transaction. An accepted item
// is held in the input register, then the core updates its state and the response
// register in the same edge: one item per cycle while rsp_if.ready stays high.
// The input register refills while a response waits, so rsp_if.ready low stalls
// only once both registers are full. Synchronous reset clears all control state and
// the configuration; the text buffer holds garbage until loaded.
`default_nettype none

module char_lcd_command_sequencer (
   input  wire logic     clock,
   input  wire logic     reset,
   clcd_req_if.sink      req_if,
   clcd_rsp_if.source    rsp_if,
   clcd_csr_if.sink      csr_if
);

   logic                   in_vld_ff, in_vld_in;
   clcd_pkg::item_type     in_item_ff;
   logic                   out_vld_ff, out_vld_in;
   clcd_pkg::result_type   out_res_ff;
   clcd_pkg::result_type   core_res;
   clcd_pkg::cfg_type      cfg;
   logic                   advance;
   logic                   req_take;

   clcd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   clcd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_res)
   );

   assign advance      = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.opcode      <= req_if.opcode;
         in_item_ff.char_index  <= req_if.char_index;
         in_item_ff.char_value  <= req_if.char_value;
         in_item_ff.text_length <= req_if.text_length;
         in_item_ff.line_select <= req_if.line_select;
         in_item_ff.position    <= req_if.position;
      end
      if (advance) out_res_ff <= core_res;
   end

   assign rsp_if.valid      = out_vld_ff;
   assign rsp_if.status     = out_res_ff.status;
   assign rsp_if.reg_select = out_res_ff.reg_select;
   assign rsp_if.enable     = out_res_ff.enable;
   assign rsp_if.data_bus   = out_res_ff.data_bus;
   assign rsp_if.done_kind  = out_res_ff.done_kind;
   assign rsp_if.init_done  = out_res_ff.init_done;

endmodule

`default_nettype wire

@@ hdl/clcd_csr.sv @@
// Configuration register bank of the sequencer.
`default_nettype none

module clcd_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   clcd_csr_if.sink               csr_if,
   output clcd_pkg::cfg_type      cfg
);

   clcd_pkg::cfg_type cfg_ff;
   clcd_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            clcd_pkg::CSR_FUNCTION: cfg_in.function_bits = csr_if.data[1:0];
            clcd_pkg::CSR_DISPLAY:  cfg_in.display_bits  = csr_if.data[2:0];
            clcd_pkg::CSR_ENTRY:    cfg_in.entry_bits    = csr_if.data[1:0];
            clcd_pkg::CSR_LINE_ONE: cfg_in.line_one_cmd  = csr_if.data;
            clcd_pkg::CSR_LINE_TWO: cfg_in.line_two_cmd  = csr_if.data;
            clcd_pkg::CSR_MAX_POS:  cfg_in.max_position  = csr_if.data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.function_bits <= 2'd2;
         cfg_ff.display_bits  <= 3'd4;
         cfg_ff.entry_bits    <= 2'd2;
         cfg_ff.line_one_cmd  <= 8'd128;
         cfg_ff.line_two_cmd  <= 8'd192;
         cfg_ff.max_position  <= 8'd15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/clcd_core.sv @@
// Bus sequencing state, text buffer and per-item update logic.
`default_nettype none

module clcd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire clcd_pkg::item_type  item,
   input  wire clcd_pkg::cfg_type   cfg,
   output clcd_pkg::result_type     result
);

   logic [1:0]                        init_step_ff, init_step_in;
   logic                              init_fin_ff, init_fin_in;
   clcd_pkg::active_type              active_ff, active_in;
   logic                              enable_ff, enable_in;
   logic [clcd_pkg::BYTE_W-1:0]       bus_ff, bus_in;
   logic                              select_ff, select_in;
   logic [clcd_pkg::TEXT_LEN_W-1:0]   sent_ff, sent_in;
   logic [clcd_pkg::TEXT_LEN_W-1:0]   length_ff, length_in;
   logic [clcd_pkg::BYTE_W-1:0]       move_line_ff, move_line_in;
   logic [clcd_pkg::BYTE_W-1:0]       move_pos_ff, move_pos_in;

   logic [clcd_pkg::BYTE_W-1:0]       buf_ff [clcd_pkg::BUFFER_DEPTH];
   logic                              buf_we;
   logic [clcd_pkg::BUF_IDX_W-1:0]    buf_waddr;
   logic [clcd_pkg::BYTE_W-1:0]       buf_rdata;
   logic [clcd_pkg::BYTE_W-1:0]       init_cmd;
   logic [clcd_pkg::STATUS_W-1:0]     status;
   logic [clcd_pkg::DONE_W-1:0]       done;
   logic                              move_ok;
   logic                              len_bad;

   always_comb begin
      case (init_step_ff)
         2'd0:    init_cmd = clcd_pkg::CMD_FUNCTION | {4'd0, cfg.function_bits, 2'd0};
         2'd1:    init_cmd = clcd_pkg::CMD_DISPLAY | {5'd0, cfg.display_bits};
         2'd2:    init_cmd = clcd_pkg::CMD_CLEAR;
         default: init_cmd = clcd_pkg::CMD_ENTRY | {6'd0, cfg.entry_bits};
      endcase
   end

   // the buffer is read only while the sent count is below the write length, which never exceeds the depth
   assign buf_rdata = buf_ff[sent_ff[clcd_pkg::BUF_IDX_W-1:0]];

   assign move_ok = ((item.line_select == cfg.line_one_cmd) ||
                     (item.line_select == cfg.line_two_cmd)) &&
                    (item.position <= cfg.max_position);
   assign len_bad = (item.text_length == '0) ||
                    (int'(item.text_length) > clcd_pkg::BUFFER_DEPTH);

   assign buf_we    = advance && (item.opcode == clcd_pkg::OPC_LOAD) &&
                      (int'(item.char_index) < clcd_pkg::BUFFER_DEPTH);
   assign buf_waddr = clcd_pkg::BUF_IDX_W'(item.char_index);

   always_comb begin
      init_step_in = init_step_ff;
      init_fin_in  = init_fin_ff;
      active_in    = active_ff;
      enable_in    = enable_ff;
      bus_in       = bus_ff;
      select_in    = select_ff;
      sent_in      = sent_ff;
      length_in    = length_ff;
      move_line_in = move_line_ff;
      move_pos_in  = move_pos_ff;
      status       = clcd_pkg::STATUS_ACCEPTED;
      done         = clcd_pkg::DONE_NONE;

      case (item.opcode)
         clcd_pkg::OPC_TICK: begin
            if (!init_fin_ff) begin
               if (enable_ff) begin
                  enable_in = 1'b0;
                  if (init_step_ff != 2'd3) init_step_in = init_step_ff + 2'd1;
                  else init_fin_in = 1'b1;
               end else begin
                  bus_in    = init_cmd;
                  select_in = 1'b0;
                  enable_in = 1'b1;
               end
            end else begin
               case (active_ff)
                  clcd_pkg::ACT_WRITE: begin
                     if (enable_ff) begin
                        enable_in = 1'b0;
                     end else if (sent_ff >= length_ff) begin
                        active_in = clcd_pkg::ACT_IDLE;
                        sent_in   = '0;
                        done      = clcd_pkg::DONE_WRITE;
                     end else begin
                        bus_in    = buf_rdata;
                        select_in = 1'b1;
                        enable_in = 1'b1;
                        sent_in   = sent_ff + 1'b1;
                     end
                  end
                  clcd_pkg::ACT_CLEAR: begin
                     if (enable_ff) begin
                        enable_in = 1'b0;
                        active_in = clcd_pkg::ACT_IDLE;
                        done      = clcd_pkg::DONE_CLEAR;
                     end else begin
                        bus_in    = clcd_pkg::CMD_CLEAR;
                        select_in = 1'b0;
                        enable_in = 1'b1;
                     end
                  end
                  clcd_pkg::ACT_MOVE: begin
                     if (enable_ff) begin
                        enable_in    = 1'b0;
                        active_in    = clcd_pkg::ACT_IDLE;
                        move_line_in = '0;
                        move_pos_in  = '0;
                        done         = clcd_pkg::DONE_MOVE;
                     end else begin
                        bus_in    = move_line_ff + move_pos_ff;
                        select_in = 1'b0;
                        enable_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         clcd_pkg::OPC_LOAD: ;
         clcd_pkg::OPC_WRITE: begin
            if (len_bad) begin
               status = clcd_pkg::STATUS_BAD;
            end else if (active_ff != clcd_pkg::ACT_IDLE) begin
               status = clcd_pkg::STATUS_INUSE;
            end else begin
               active_in = clcd_pkg::ACT_WRITE;
               length_in = item.text_length;
               sent_in   = '0;
            end
         end
         clcd_pkg::OPC_CLEAR: begin
            if (active_ff != clcd_pkg::ACT_IDLE) status = clcd_pkg::STATUS_INUSE;
            else active_in = clcd_pkg::ACT_CLEAR;
         end
         clcd_pkg::OPC_MOVE: begin
            // argument check takes priority over busy
            if (!move_ok) begin
               status = clcd_pkg::STATUS_BAD;
            end else if (active_ff != clcd_pkg::ACT_IDLE) begin
               status = clcd_pkg::STATUS_INUSE;
            end else begin
               active_in    = clcd_pkg::ACT_MOVE;
               move_line_in = item.line_select;
               move_pos_in  = item.position;
            end
         end
         default: status = clcd_pkg::STATUS_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_step_ff <= '0;
         init_fin_ff  <= 1'b0;
         active_ff    <= clcd_pkg::ACT_IDLE;
         enable_ff    <= 1'b0;
         bus_ff       <= '0;
         select_ff    <= 1'b0;
         sent_ff      <= '0;
         length_ff    <= '0;
         move_line_ff <= '0;
         move_pos_ff  <= '0;
      end else if (advance) begin
         init_step_ff <= init_step_in;
         init_fin_ff  <= init_fin_in;
         active_ff    <= active_in;
         enable_ff    <= enable_in;
         bus_ff       <= bus_in;
         select_ff    <= select_in;
         sent_ff      <= sent_in;
         length_ff    <= length_in;
         move_line_ff <= move_line_in;
         move_pos_ff  <= move_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) buf_ff[buf_waddr] <= item.char_value;
   end

   always_comb begin
      result.status     = status;
      result.reg_select = select_in;
      result.enable     = enable_in;
      result.data_bus   = bus_in;
      result.done_kind  = done;
      result.init_done  = init_fin_in;
   end

endmodule

`default_nettype wire
